/* sv/mbe_pkg.sv */
package mbe_pkg;

   localparam int DataWidth = 64;
   localparam int TolWidth  = 59;
   localparam int IterWidth = 16;
   localparam int HalfWidth = 32;

   typedef logic [DataWidth-1:0] word_type;
   typedef logic [TolWidth-1:0]  tol_type;
   typedef logic [IterWidth-1:0] iter_type;

   typedef struct packed {
      logic     start;
      word_type a;
      word_type b;
   } mul_req_type;

   typedef struct packed {
      logic     done;
      word_type q;
   } mul_rsp_type;

   function automatic word_type magnitude(input word_type v);
      magnitude = v[DataWidth-1] ? (~v + word_type'(1)) : v;
   endfunction

   function automatic word_type sat_add(input word_type a, input word_type b);
      logic [DataWidth:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[DataWidth] ? '1 : s[DataWidth-1:0];
   endfunction

endpackage

/* sv/mbe_if.sv */
interface mbe_req_if;
   import mbe_pkg::*;
   logic     valid;
   logic     ready;
   word_type c_real;
   word_type c_imag;
   modport source (output valid, c_real, c_imag, input ready);
   modport sink (input valid, c_real, c_imag, output ready);
endinterface

interface mbe_rsp_if;
   import mbe_pkg::*;
   logic     valid;
   logic     ready;
   logic     never_escaped;
   iter_type escape_iteration;
   modport source (output valid, never_escaped, escape_iteration, input ready);
   modport sink (input valid, never_escaped, escape_iteration, output ready);
endinterface

interface mbe_csr_if;
   import mbe_pkg::*;
   logic    valid;
   logic    ready;
   tol_type data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

/* sv/mbe_mul_cell.sv */
module mbe_mul_cell (
   input  logic                         clock,
   input  logic                         load,
   input  logic [mbe_pkg::HalfWidth-1:0] a_part,
   input  logic [mbe_pkg::HalfWidth-1:0] b_part,
   input  logic [2*mbe_pkg::HalfWidth-1:0] acc_prev,
   output logic [2*mbe_pkg::HalfWidth-1:0] prod
);
   import mbe_pkg::*;

   logic [2*HalfWidth-1:0] prod_ff;
   logic [2*HalfWidth-1:0] prod_in;

   always_comb begin
      prod_in = acc_prev;
      if (load) begin
         prod_in = a_part * b_part;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule

/* sv/mbe_mul_shift.sv */
module mbe_mul_shift #(
   parameter int Shift = 58
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mbe_pkg::mul_req_type req,
   output mbe_pkg::mul_rsp_type rsp
);
   import mbe_pkg::*;

   localparam int Cells = 4;

   logic [Cells:0]          stage_ff;
   logic [Cells:0]          stage_in;
   logic                    neg_ff;
   word_type                ma_ff, mb_ff;
   logic [HalfWidth-1:0]    a_sel [Cells];
   logic [HalfWidth-1:0]    b_sel [Cells];
   logic [2*HalfWidth-1:0]  part [Cells];
   logic [2*DataWidth-1:0]  acc_ff, acc_in;
   logic                    done_ff;
   word_type                q_ff, q_in;
   logic [2*DataWidth-1:0]  mask;
   logic [2*DataWidth-1:0]  sh;

   assign a_sel[0] = ma_ff[HalfWidth-1:0];
   assign b_sel[0] = mb_ff[HalfWidth-1:0];
   assign a_sel[1] = ma_ff[HalfWidth-1:0];
   assign b_sel[1] = mb_ff[DataWidth-1:HalfWidth];
   assign a_sel[2] = ma_ff[DataWidth-1:HalfWidth];
   assign b_sel[2] = mb_ff[HalfWidth-1:0];
   assign a_sel[3] = ma_ff[DataWidth-1:HalfWidth];
   assign b_sel[3] = mb_ff[DataWidth-1:HalfWidth];

   // each cell forms one partial product then passes it down the row
   for (genvar k = 0; k < Cells; k++) begin : g_cell
      mbe_mul_cell u_cell (
         .clock   (clock),
         .load    (stage_ff[0]),
         .a_part  (a_sel[k]),
         .b_part  (b_sel[k]),
         .acc_prev(k + 1 < Cells ? part[(k + 1) % Cells] : '0),
         .prod    (part[k])
      );
   end

   assign stage_in = {stage_ff[Cells-1:0], req.start};
   assign mask = (128'(1) << Shift) - 128'(1);
   assign sh = acc_ff >> Shift;

   always_comb begin
      acc_in = acc_ff;
      if (stage_ff[1]) begin
         acc_in = 128'(part[0]);
      end else if (stage_ff[2]) begin
         acc_in = acc_ff + (128'(part[0]) << HalfWidth);
      end else if (stage_ff[3]) begin
         acc_in = acc_ff + (128'(part[0]) << HalfWidth);
      end else if (stage_ff[Cells]) begin
         acc_in = acc_ff + (128'(part[0]) << DataWidth);
      end
      q_in = sh[DataWidth-1:0];
      if (neg_ff) begin
         q_in = ~(sh[DataWidth-1:0] + word_type'((acc_ff & mask) != '0)) + word_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= 1'b0;
         if (stage_ff[Cells]) begin
            done_ff <= 1'b1;
         end
      end
      if (req.start) begin
         ma_ff  <= magnitude(req.a);
         mb_ff  <= magnitude(req.b);
         neg_ff <= req.a[DataWidth-1] ^ req.b[DataWidth-1];
      end
      acc_ff <= acc_in;
      q_ff <= q_in;
   end

   logic done_d_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         done_d_ff <= 1'b0;
      end else begin
         done_d_ff <= done_ff;
      end
   end

   assign rsp.done = done_d_ff;
   assign rsp.q    = q_ff;
endmodule

/* sv/mandelbrot_escape_iteration_unit.sv */
// Escape-time evaluator for one complex point c in two's complement fixed
// point. z starts at c and is updated as z*z + c; each iteration first tests
// the L1 norm against 4 and answers that index on escape. From iteration
// MAX_ITERATIONS/4 on, z is saved once and the point is reported bounded when
// the L1 distance to the saved point drops below csr_data; reaching
// MAX_ITERATIONS also reports bounded. The three products of one iteration
// run in parallel in three rows of 32x32 partial-product cells; each iteration
// runs the escape test, the multiply and the cycle check. One point is in
// flight at a time; the result register lets the next point be taken while a
// result waits, and a finished point stalls until that register is free.
module mandelbrot_escape_iteration_unit #(
   parameter int MAX_ITERATIONS = 65536,
   parameter int FRACTION_BITS  = 58
) (
   input logic      clock,
   input logic      reset,
   mbe_req_if.sink   req,
   mbe_rsp_if.source rsp,
   mbe_csr_if.sink   csr
);
   import mbe_pkg::*;

   localparam int CntWidth   = $clog2(MAX_ITERATIONS + 1);
   localparam int CycleBegin = MAX_ITERATIONS / 4;
   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StTest = 2'd1;
   localparam logic [1:0] StMul  = 2'd2;
   localparam logic [1:0] StChk  = 2'd3;

   logic [1:0]          state_ff, state_in;
   word_type            cr_ff, ci_ff, zr_ff, zi_ff, tr_ff, ti_ff;
   logic [CntWidth-1:0] j_ff;
   tol_type             tol_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_free;
   logic                never_ff;
   iter_type            iter_ff;
   mul_req_type         m_rr, m_ii, m_ri;
   mul_rsp_type         p_rr, p_ii, p_ri;
   word_type            nr, ni, four, norm, cyc_dist;
   logic                mul_go;

   assign four = word_type'(4) << FRACTION_BITS;
   assign norm = sat_add(magnitude(zr_ff), magnitude(zi_ff));
   assign cyc_dist = sat_add(magnitude(tr_ff - zr_ff), magnitude(ti_ff - zi_ff));
   assign mul_go = (state_ff == StTest) && (norm < four);

   assign m_rr = '{start: mul_go, a: zr_ff, b: zr_ff};
   assign m_ii = '{start: mul_go, a: zi_ff, b: zi_ff};
   assign m_ri = '{start: mul_go, a: zr_ff, b: zi_ff};

   mbe_mul_shift #(.Shift(FRACTION_BITS)) u_rr (
      .clock(clock), .reset(reset), .req(m_rr), .rsp(p_rr));
   mbe_mul_shift #(.Shift(FRACTION_BITS)) u_ii (
      .clock(clock), .reset(reset), .req(m_ii), .rsp(p_ii));
   mbe_mul_shift #(.Shift(FRACTION_BITS - 1)) u_ri (
      .clock(clock), .reset(reset), .req(m_ri), .rsp(p_ri));

   assign nr = p_rr.q - p_ii.q + cr_ff;
   assign ni = p_ri.q + ci_ff;

   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == StIdle);
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.never_escaped = never_ff;
   assign rsp.escape_iteration = iter_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StIdle: if (req.valid && req.ready) state_in = StTest;
         StTest: begin
            if (norm < four) begin
               state_in = StMul;
            end else if (rsp_free) begin
               state_in = StIdle;
            end
         end
         StMul:  if (p_rr.done) state_in = StChk;
         StChk: begin
            if ((j_ff >= CntWidth'(CycleBegin) && cyc_dist < 64'(tol_ff))
                || j_ff == CntWidth'(MAX_ITERATIONS - 1)) begin
               if (rsp_free) state_in = StIdle;
            end else begin
               state_in = StTest;
            end
         end
         default: state_in = StIdle;
      endcase
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (state_ff != StIdle && state_in == StIdle) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= tol_type'(1) << (FRACTION_BITS - 40);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid && csr.ready) begin
            tol_ff <= csr.data;
         end
      end
      case (state_ff)
         StIdle: begin
            if (req.valid && req.ready) begin
               cr_ff <= req.c_real;
               ci_ff <= req.c_imag;
               zr_ff <= req.c_real;
               zi_ff <= req.c_imag;
               j_ff  <= '0;
            end
         end
         StTest: begin
            if (j_ff == CntWidth'(CycleBegin)) begin
               tr_ff <= zr_ff;
               ti_ff <= zi_ff;
            end
            if (state_in == StIdle) begin
               never_ff <= 1'b0;
               iter_ff  <= (j_ff > CntWidth'(65535)) ? '1 : iter_type'(j_ff);
            end
         end
         StMul: begin
            if (p_rr.done) begin
               zr_ff <= nr;
               zi_ff <= ni;
            end
         end
         StChk: begin
            if (state_in == StTest) begin
               j_ff <= j_ff + CntWidth'(1);
            end
            if (state_in == StIdle) begin
               never_ff <= 1'b1;
               iter_ff  <= '0;
            end
         end
         default: ;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != StIdle) |-> !req.ready)
      else $error("input taken while busy");
   a_bounded_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.never_escaped) |-> (rsp.escape_iteration == '0))
      else $error("bounded point with nonzero index");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid)
      else $error("result dropped");
`endif
endmodule
